// ===== hw/rtl/slxfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slxfp_pkg
// Shared types and constants for the sync/length framed parser and its checker.
// ----------------------------------------------------------------------------
package slxfp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam status_t ST_NONE   = 2'd0;
  localparam status_t ST_ACCEPT = 2'd1;
  localparam status_t ST_BADSUM = 2'd2;
  localparam status_t ST_REJECT = 2'd3;

  localparam cfg_idx_t REG_SYNC_FIRST   = 2'd0;
  localparam cfg_idx_t REG_SYNC_SECOND  = 2'd1;
  localparam cfg_idx_t REG_FRAME_IDENT  = 2'd2;
  localparam cfg_idx_t REG_MAX_BODY_END = 2'd3;

  localparam byte_t SYNC_FIRST_RST   = 8'h55;
  localparam byte_t SYNC_SECOND_RST  = 8'hAA;
  localparam byte_t FRAME_IDENT_RST  = 8'hA1;
  localparam byte_t MAX_BODY_END_RST = 8'd158;

  localparam byte_t MIN_LEN       = 8'd6;
  localparam byte_t LEN_TO_END    = 8'd2;
  localparam byte_t PAYLOAD_FIRST = 8'd4;
  localparam byte_t PAYLOAD_TAIL  = 8'd3;

endpackage

// ===== hw/rtl/sync_length_xor_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser_core
// Hunts for sync/length/ident framed packets in a byte stream, flags payload
// bytes and checks the trailing XOR checksum. One result word per input word.
// Result word is registered on input acceptance. Throughput: 1 word per
// cycle unless out_stall holds it; the output register frees as it is taken.
// Reset: synchronous active-low rst_n; parser waits for first sync byte,
// counters clear, config registers return to their defaults.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser_core #(
  parameter int unsigned FRAME_BUFFER_BYTES = 160
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [slxfp_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [slxfp_pkg::BYTE_W-1:0]       out_echo_byte,
  output logic                               out_payload_valid,
  output logic [slxfp_pkg::BYTE_W-1:0]       out_payload_index,
  output logic [slxfp_pkg::STATUS_W-1:0]     out_frame_status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [slxfp_pkg::PADDR_W-1:0]      paddr,
  input  logic [slxfp_pkg::PDATA_W-1:0]      pwdata,
  output logic [slxfp_pkg::PDATA_W-1:0]      prdata,
  output logic                               pready
);

  localparam slxfp_pkg::byte_t BUF_LIMIT =
    slxfp_pkg::BYTE_W'(FRAME_BUFFER_BYTES - 2);

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_IDENT = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  phase_t               phase_r, phase_nxt;
  slxfp_pkg::byte_t     count_r, count_nxt;
  slxfp_pkg::byte_t     body_end_r, body_end_nxt;
  slxfp_pkg::byte_t     xor_r, xor_nxt;

  slxfp_pkg::byte_t     sync_first_r, sync_second_r, frame_ident_r, max_body_end_r;

  logic                 out_valid_r, out_valid_nxt;
  slxfp_pkg::byte_t     echo_r;
  logic                 pvalid_r, pvalid_nxt;
  slxfp_pkg::byte_t     pidx_r, pidx_nxt;
  slxfp_pkg::status_t   status_r, status_nxt;

  logic                 accept_in;
  logic                 cfg_wr;
  slxfp_pkg::cfg_idx_t  cfg_idx;
  slxfp_pkg::byte_t     len_limit;
  slxfp_pkg::byte_t     b;

  assign in_stall  = out_valid_r & out_stall;
  assign accept_in = in_valid & ~in_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign cfg_idx   = paddr[3:2];
  assign b         = in_rx_byte;
  assign len_limit = (max_body_end_r < BUF_LIMIT) ? max_body_end_r : BUF_LIMIT;

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    body_end_nxt = body_end_r;
    xor_nxt      = xor_r;
    pvalid_nxt   = 1'b0;
    pidx_nxt     = '0;
    status_nxt   = slxfp_pkg::ST_NONE;
    case (phase_r)
      PH_SYNC2: begin
        if (b == sync_second_r) begin
          xor_nxt   = xor_r ^ b;
          count_nxt = count_r + 8'd1;
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_LEN: begin
        if ((b < slxfp_pkg::MIN_LEN) || ((b - slxfp_pkg::LEN_TO_END) > len_limit)) begin
          status_nxt = slxfp_pkg::ST_REJECT;
          phase_nxt  = PH_SYNC1;
        end else begin
          body_end_nxt = b - slxfp_pkg::LEN_TO_END;
          xor_nxt      = xor_r ^ b;
          count_nxt    = count_r + 8'd1;
          phase_nxt    = PH_IDENT;
        end
      end
      PH_IDENT: begin
        if (b == frame_ident_r) begin
          xor_nxt   = xor_r ^ b;
          count_nxt = count_r + 8'd1;
          phase_nxt = PH_DATA;
        end else begin
          status_nxt = slxfp_pkg::ST_REJECT;
          phase_nxt  = PH_SYNC1;
        end
      end
      PH_DATA: begin
        if ((count_r >= slxfp_pkg::PAYLOAD_FIRST) &&
            (({1'b0, count_r} + {1'b0, slxfp_pkg::PAYLOAD_TAIL}) <= {1'b0, body_end_r})) begin
          pvalid_nxt = 1'b1;
          pidx_nxt   = count_r - slxfp_pkg::PAYLOAD_FIRST;
        end
        if (count_r >= body_end_r) begin
          phase_nxt = PH_CHECK;
        end
        xor_nxt   = xor_r ^ b;
        count_nxt = count_r + 8'd1;
      end
      PH_CHECK: begin
        status_nxt = (b == xor_r) ? slxfp_pkg::ST_ACCEPT : slxfp_pkg::ST_BADSUM;
        phase_nxt  = PH_SYNC1;
      end
      default: begin
        if (b == sync_first_r) begin
          count_nxt = 8'd1;
          xor_nxt   = b;
          phase_nxt = PH_SYNC2;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
    endcase
  end

  always_comb begin
    if (accept_in) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC1;
      count_r     <= '0;
      body_end_r  <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept_in) begin
        phase_r    <= phase_nxt;
        count_r    <= count_nxt;
        body_end_r <= body_end_nxt;
        xor_r      <= xor_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      echo_r   <= b;
      pvalid_r <= pvalid_nxt;
      pidx_r   <= pidx_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r   <= slxfp_pkg::SYNC_FIRST_RST;
      sync_second_r  <= slxfp_pkg::SYNC_SECOND_RST;
      frame_ident_r  <= slxfp_pkg::FRAME_IDENT_RST;
      max_body_end_r <= slxfp_pkg::MAX_BODY_END_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        slxfp_pkg::REG_SYNC_FIRST:   sync_first_r   <= pwdata[7:0];
        slxfp_pkg::REG_SYNC_SECOND:  sync_second_r  <= pwdata[7:0];
        slxfp_pkg::REG_FRAME_IDENT:  frame_ident_r  <= pwdata[7:0];
        slxfp_pkg::REG_MAX_BODY_END: max_body_end_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      slxfp_pkg::REG_SYNC_FIRST:   prdata = {24'd0, sync_first_r};
      slxfp_pkg::REG_SYNC_SECOND:  prdata = {24'd0, sync_second_r};
      slxfp_pkg::REG_FRAME_IDENT:  prdata = {24'd0, frame_ident_r};
      slxfp_pkg::REG_MAX_BODY_END: prdata = {24'd0, max_body_end_r};
      default:                     prdata = '0;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_echo_byte     = echo_r;
  assign out_payload_valid = pvalid_r;
  assign out_payload_index = pidx_r;
  assign out_frame_status  = status_r;

endmodule

// ===== hw/rtl/slxfp_checker.sv =====
// ----------------------------------------------------------------------------
// slxfp_checker
// Port-level checks for the framed parser, bound to its core module.
// ----------------------------------------------------------------------------
module slxfp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [slxfp_pkg::BYTE_W-1:0]    in_rx_byte,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [slxfp_pkg::BYTE_W-1:0]    out_echo_byte,
  input logic                            out_payload_valid,
  input logic [slxfp_pkg::BYTE_W-1:0]    out_payload_index,
  input logic [slxfp_pkg::STATUS_W-1:0]  out_frame_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_echo_byte) &&
      $stable(out_frame_status))
    else $error("stalled result word changed");

  a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no result");

  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_echo_byte == $past(in_rx_byte))
    else $error("echo byte mismatch");

  a_payload_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_frame_status == slxfp_pkg::ST_NONE)
    else $error("payload byte carries a frame status");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_index == '0)
    else $error("payload index nonzero outside payload");

endmodule

bind sync_length_xor_frame_parser_core slxfp_checker u_slxfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_rx_byte        (in_rx_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_echo_byte     (out_echo_byte),
  .out_payload_valid (out_payload_valid),
  .out_payload_index (out_payload_index),
  .out_frame_status  (out_frame_status)
);
